### rtl/mtd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Morton tile RGB565 detiler.
// No dependencies; used by the interfaces and every detiler module.
package mtd_pkg;

  // Default tile count limits (top-level parameter defaults)
  localparam int unsigned MaxTilesAcrossDef = 64;
  localparam int unsigned MaxTilesDownDef   = 64;

  // Field widths
  localparam int unsigned PixW   = 16;
  localparam int unsigned AByteW = 8;
  localparam int unsigned PosW   = 9;
  localparam int unsigned ArgbW  = 32;
  localparam int unsigned CfgW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PitW   = 6;   // pixel index inside an 8x8 tile

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TILES_ACROSS = 2'd0,
    CFG_TILES_DOWN   = 2'd1,
    CFG_ALPHA_MODE   = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] TilesAcrossRst = 7'd6;
  localparam logic [CfgW-1:0] TilesDownRst   = 7'd6;

  // Configuration register bundle
  typedef struct packed {
    logic [CfgW-1:0] tiles_across;
    logic [CfgW-1:0] tiles_down;
    logic            alpha_mode;
  } cfg_t;

  // Image position of one pixel, from the tile walker
  typedef struct packed {
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic            odd;          // odd pixel index: uses the high alpha nibble
    logic            image_done;
  } pos_t;

endpackage

### rtl/mtd_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the detiler input and result channels.
// Depends on mtd_pkg for field widths.
interface mtd_in_if;
  logic                         valid;
  logic                         ready;
  logic [mtd_pkg::PixW-1:0]     pixel_rgb565;
  logic [mtd_pkg::AByteW-1:0]   alpha_byte;

  modport source (output valid, output pixel_rgb565, output alpha_byte, input ready);
  modport sink   (input valid, input pixel_rgb565, input alpha_byte, output ready);
endinterface

interface mtd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mtd_pkg::PosW-1:0]    pos_x;
  logic [mtd_pkg::PosW-1:0]    pos_y;
  logic [mtd_pkg::ArgbW-1:0]   argb;
  logic                        image_done;

  modport source (output valid, output pos_x, output pos_y, output argb,
                  output image_done, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input argb,
                  input image_done, output ready);
endinterface

### rtl/morton_tile_rgb565_detiler_core.sv
`timescale 1ns / 1ps
// Morton tile RGB565 detiler, top level. An input transfer passes the input
// register, then the result register, before its result is valid.
// Throughput: one pixel per cycle unless the sink stalls; the walker updates per pixel.
// The input register lets one pixel in while a result waits on a stalled sink.
// Reset (async, active low) clears counters, valid flags and config to
// tiles 6x6, opaque alpha. Depends on mtd_pkg, mtd_if, mtd_tile_walker, mtd_color_conv.
module morton_tile_rgb565_detiler_core #(
  parameter int unsigned MAX_TILES_ACROSS = mtd_pkg::MaxTilesAcrossDef,
  parameter int unsigned MAX_TILES_DOWN   = mtd_pkg::MaxTilesDownDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mtd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mtd_pkg::CfgW-1:0]    cfg_wdata_i,
  mtd_in_if.sink                      in_i,
  mtd_out_if.source                   out_o
);
  import mtd_pkg::*;

  cfg_t cfg_q;

  logic             in_xfer;
  logic             a_adv;
  pos_t             cur_pos;

  logic             a_valid_q;
  logic [PixW-1:0]  a_pix_q;
  logic [AByteW-1:0] a_abyte_q;
  pos_t             a_pos_q;

  logic             b_valid_q;
  logic [PosW-1:0]  b_pos_x_q, b_pos_y_q;
  logic [ArgbW-1:0] b_argb_q;
  logic             b_done_q;
  logic [ArgbW-1:0] argb;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tiles_across <= TilesAcrossRst;
      cfg_q.tiles_down   <= TilesDownRst;
      cfg_q.alpha_mode   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TILES_ACROSS: cfg_q.tiles_across <= cfg_wdata_i;
        CFG_TILES_DOWN:   cfg_q.tiles_down   <= cfg_wdata_i;
        CFG_ALPHA_MODE:   cfg_q.alpha_mode   <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  // Handshake: result register moves when empty or taken
  assign a_adv      = !b_valid_q || out_o.ready;
  assign in_i.ready = !a_valid_q || a_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  mtd_tile_walker #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILES_DOWN   (MAX_TILES_DOWN)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .advance_i (in_xfer),
    .pos_o     (cur_pos)
  );

  mtd_color_conv u_conv (
    .pixel_rgb565_i (a_pix_q),
    .alpha_byte_i   (a_abyte_q),
    .odd_i          (a_pos_q.odd),
    .alpha_mode_i   (cfg_q.alpha_mode),
    .argb_o         (argb)
  );

  // Input stage: pixel fields and its position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_pix_q   <= in_i.pixel_rgb565;
      a_abyte_q <= in_i.alpha_byte;
      a_pos_q   <= cur_pos;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_adv) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_valid_q) begin
      b_pos_x_q <= a_pos_q.pos_x;
      b_pos_y_q <= a_pos_q.pos_y;
      b_argb_q  <= argb;
      b_done_q  <= a_pos_q.image_done;
    end
  end

  assign out_o.valid      = b_valid_q;
  assign out_o.pos_x      = b_pos_x_q;
  assign out_o.pos_y      = b_pos_y_q;
  assign out_o.argb       = b_argb_q;
  assign out_o.image_done = b_done_q;

endmodule

### rtl/mtd_tile_walker.sv
`timescale 1ns / 1ps
// Tile walker: pixel-in-tile, tile column and tile row counters, plus the
// Morton swizzle into image coordinates. Depends on mtd_pkg.
module mtd_tile_walker #(
  parameter int unsigned MAX_TILES_ACROSS = mtd_pkg::MaxTilesAcrossDef,
  parameter int unsigned MAX_TILES_DOWN   = mtd_pkg::MaxTilesDownDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mtd_pkg::cfg_t cfg_i,
  input  logic          advance_i,  // one pixel transfer accepted
  output mtd_pkg::pos_t pos_o
);
  import mtd_pkg::*;

  localparam int unsigned ColW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int unsigned RowW = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
  localparam int unsigned CntW = CfgW + 1;  // holds a tile count up to 128
  localparam logic [CntW-1:0] MaxAcross = CntW'(MAX_TILES_ACROSS);
  localparam logic [CntW-1:0] MaxDown   = CntW'(MAX_TILES_DOWN);
  localparam logic [PitW-1:0] LastPix   = '1;

  logic [PitW-1:0] pit_q, pit_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  logic [CntW-1:0] eff_across, eff_down;
  logic [CntW-1:0] col_p1, row_p1;
  logic            last_col, last_row, last_pix;

  // Clamp the tile counts: zero acts as one, above the limit acts as the limit
  always_comb begin
    if (cfg_i.tiles_across == '0) begin
      eff_across = CntW'(1);
    end else if ({1'b0, cfg_i.tiles_across} > MaxAcross) begin
      eff_across = MaxAcross;
    end else begin
      eff_across = {1'b0, cfg_i.tiles_across};
    end
    if (cfg_i.tiles_down == '0) begin
      eff_down = CntW'(1);
    end else if ({1'b0, cfg_i.tiles_down} > MaxDown) begin
      eff_down = MaxDown;
    end else begin
      eff_down = {1'b0, cfg_i.tiles_down};
    end
  end

  assign col_p1   = CntW'(col_q) + CntW'(1);
  assign row_p1   = CntW'(row_q) + CntW'(1);
  assign last_col = (col_p1 >= eff_across);
  assign last_row = (row_p1 >= eff_down);
  assign last_pix = (pit_q == LastPix);

  // Morton swizzle: x = {i4,i2,i0}, y = {i5,i3,i1}
  assign pos_o.pos_x      = PosW'({col_q, pit_q[4], pit_q[2], pit_q[0]});
  assign pos_o.pos_y      = PosW'({row_q, pit_q[5], pit_q[3], pit_q[1]});
  assign pos_o.odd        = pit_q[0];
  assign pos_o.image_done = last_pix && last_col && last_row;

  // Counter update per accepted pixel
  always_comb begin
    pit_d = pit_q;
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (last_pix) begin
        pit_d = '0;
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_p1[RowW-1:0];
        end else begin
          col_d = col_p1[ColW-1:0];
        end
      end else begin
        pit_d = pit_q + PitW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pit_q <= '0;
      col_q <= '0;
      row_q <= '0;
    end else begin
      pit_q <= pit_d;
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/mtd_color_conv.sv
`timescale 1ns / 1ps
// Color conversion: RGB565 plus alpha nibble (or opaque alpha) to ARGB32 by bit replication.
// Depends on mtd_pkg.
module mtd_color_conv (
  input  logic [mtd_pkg::PixW-1:0]   pixel_rgb565_i,
  input  logic [mtd_pkg::AByteW-1:0] alpha_byte_i,
  input  logic                       odd_i,
  input  logic                       alpha_mode_i,
  output logic [mtd_pkg::ArgbW-1:0]  argb_o
);
  import mtd_pkg::*;

  logic [4:0] r5, b5;
  logic [5:0] g6;
  logic [3:0] nib;
  logic [7:0] a8, r8, g8, b8;

  assign r5 = pixel_rgb565_i[15:11];
  assign g6 = pixel_rgb565_i[10:5];
  assign b5 = pixel_rgb565_i[4:0];

  // Channel widening by replicating the top bits
  assign r8 = {r5, r5[4:2]};
  assign g8 = {g6, g6[5:4]};
  assign b8 = {b5, b5[4:2]};

  // Odd pixels take the high nibble; nibble * 17 is the nibble repeated
  assign nib = odd_i ? alpha_byte_i[7:4] : alpha_byte_i[3:0];
  assign a8  = alpha_mode_i ? {nib, nib} : 8'hFF;

  assign argb_o = {a8, r8, g8, b8};

endmodule

### tb/sv/mtd_detiler_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Morton tile RGB565 detiler: watches the config port and both
// stream channels, predicts each pixel's position and color, and compares the results.
// Depends on mtd_pkg and mtd_if.
module mtd_detiler_checker #(
  parameter int unsigned MAX_TILES_ACROSS = mtd_pkg::MaxTilesAcrossDef,
  parameter int unsigned MAX_TILES_DOWN   = mtd_pkg::MaxTilesDownDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mtd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mtd_pkg::CfgW-1:0]    cfg_wdata_i,
  mtd_in_if                           in_mon,
  mtd_out_if                          out_mon,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);
  import mtd_pkg::*;

  typedef struct packed {
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [ArgbW-1:0] argb;
    logic             image_done;
  } pixel_out_t;

  // Shadow of the config registers and the tile walker
  logic [CfgW-1:0] tiles_across_q = TilesAcrossRst;
  logic [CfgW-1:0] tiles_down_q   = TilesDownRst;
  logic            alpha_mode_q   = 1'b0;
  logic [PitW-1:0] pit            = '0;
  int unsigned     tile_col       = 0;
  int unsigned     tile_row       = 0;

  pixel_out_t  expected_pixels[$];
  int unsigned outstanding = 0;
  int unsigned mismatches  = 0;

  assign pending_o    = outstanding;
  assign fail_count_o = mismatches;

  // Zero acts as one tile, anything above the limit as the limit
  function automatic int unsigned clamp_tiles(logic [CfgW-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Position and color of the pixel at the walker, then step the walker
  function automatic pixel_out_t detile_pixel(logic [PixW-1:0] pix, logic [AByteW-1:0] abyte);
    int unsigned across, down, px, py;
    logic [2:0]  lx, ly;
    logic        last_col, last_row;
    logic [3:0]  nib;
    logic [7:0]  a8;
    pixel_out_t  res;
    across   = clamp_tiles(tiles_across_q, MAX_TILES_ACROSS);
    down     = clamp_tiles(tiles_down_q, MAX_TILES_DOWN);
    lx       = {pit[4], pit[2], pit[0]};
    ly       = {pit[5], pit[3], pit[1]};
    px       = tile_col * 8 + lx;
    py       = tile_row * 8 + ly;
    last_col = (tile_col + 1 >= across);
    last_row = (tile_row + 1 >= down);
    // odd pixels take the high nibble of the pair's alpha byte
    nib      = pit[0] ? abyte[7:4] : abyte[3:0];
    a8       = alpha_mode_q ? {nib, nib} : 8'hFF;

    res.pos_x      = px[PosW-1:0];
    res.pos_y      = py[PosW-1:0];
    res.argb       = {a8, pix[15:11], pix[15:13], pix[10:5], pix[10:9], pix[4:0], pix[4:2]};
    res.image_done = (&pit) && last_col && last_row;

    // a held column or row past a lowered count wraps at the tile boundary
    if (&pit) begin
      pit = '0;
      if (last_col) begin
        tile_col = 0;
        tile_row = last_row ? 0 : tile_row + 1;
      end else begin
        tile_col = tile_col + 1;
      end
    end else begin
      pit = pit + 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_out_t want;
    if (!rst_ni) begin
      tiles_across_q = TilesAcrossRst;
      tiles_down_q   = TilesDownRst;
      alpha_mode_q   = 1'b0;
      pit            = '0;
      tile_col       = 0;
      tile_row       = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_TILES_ACROSS: tiles_across_q = cfg_wdata_i;
          CFG_TILES_DOWN:   tiles_down_q   = cfg_wdata_i;
          CFG_ALPHA_MODE:   alpha_mode_q   = cfg_wdata_i[0];
          default: ;
        endcase
      end

      // Result transfer: check against the oldest pixel in flight
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: pos_x=%0d pos_y=%0d argb=%h",
                 out_mon.pos_x, out_mon.pos_y, out_mon.argb);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.pos_x !== want.pos_x) begin
            $error("pos_x mismatch: expected %0d, got %0d", want.pos_x, out_mon.pos_x);
            mismatches++;
          end
          if (out_mon.pos_y !== want.pos_y) begin
            $error("pos_y mismatch: expected %0d, got %0d", want.pos_y, out_mon.pos_y);
            mismatches++;
          end
          if (out_mon.argb !== want.argb) begin
            $error("argb mismatch: expected %h, got %h", want.argb, out_mon.argb);
            mismatches++;
          end
          if (out_mon.image_done !== want.image_done) begin
            $error("image_done mismatch: expected %0d, got %0d",
                   want.image_done, out_mon.image_done);
            mismatches++;
          end
        end
      end

      // Pixel transfer
      if (in_mon.valid && in_mon.ready)
        expected_pixels.push_back(detile_pixel(in_mon.pixel_rgb565, in_mon.alpha_byte));
    end
    outstanding = expected_pixels.size();
  end

endmodule

### tb/sv/tb_morton_tile_rgb565_detiler_core.sv
`timescale 1ns / 1ps
// Top of the detiler testbench: clock, reset, config writes, pixel stimulus and
// result back-pressure. Depends on mtd_pkg, mtd_if, mtd_detiler_checker and the core.
module tb_morton_tile_rgb565_detiler_core;
  import mtd_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  int unsigned         pending_pixels;
  int unsigned         fail_count;
  logic                result_taken = 1'b0;
  bit                  src_idle = 1'b0;
  bit                  snk_idle = 1'b0;
  int unsigned         pixels_sent = 0;

  mtd_in_if  in_ch ();
  mtd_out_if out_ch ();

  morton_tile_rgb565_detiler_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  mtd_detiler_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .pending_o    (pending_pixels),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result sink: a fresh stall is drawn after every result transfer while snk_idle is set
  always @(posedge clk_i) result_taken <= out_ch.valid && out_ch.ready;

  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (result_taken) hold = snk_idle ? $urandom_range(0, 10) : 0;
        if (hold > 0) begin
          out_ch.ready <= 1'b0;
          hold--;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Config write; called and returns at a falling edge with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // One pixel transfer; valid stays high into the next call when there is no gap
  task automatic push_pixel(input logic [PixW-1:0] pix, input logic [AByteW-1:0] abyte);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pixel_rgb565 <= pix;
    in_ch.alpha_byte   <= abyte;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    pixels_sent++;
  endtask

  task automatic push_random(input int unsigned n);
    logic [PixW-1:0] pix;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 15))
        0:       pix = '0;
        1:       pix = '1;
        default: pix = PixW'($urandom);
      endcase
      push_pixel(pix, AByteW'($urandom));
    end
  endtask

  // Hold off the sender until every pixel in flight has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_pixels != 0);
    repeat (3) @(negedge clk_i);
  endtask

  function automatic logic [CfgW-1:0] pick_tiles();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CfgW'($urandom_range(65, 127));
      2:       return 7'd64;
      3:       return CfgW'($urandom_range(4, 63));
      default: return CfgW'($urandom_range(1, 3));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_sent;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_TILES_ACROSS;
    cfg_wdata_i        = '0;
    in_ch.valid        = 1'b0;
    in_ch.pixel_rgb565 = '0;
    in_ch.alpha_byte   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero tile counts give a single 8x8 tile image
    src_idle = 1'b1;
    snk_idle = 1'b1;
    write_reg(CFG_TILES_ACROSS, 7'd0);
    write_reg(CFG_TILES_DOWN, 7'd0);
    write_reg(CFG_ALPHA_MODE, 7'd1);
    push_pixel(16'h0000, 8'h00);
    push_pixel(16'hFFFF, 8'hFF);
    push_pixel(16'hF800, 8'h0F);   // even: low nibble used
    push_pixel(16'h07E0, 8'h0F);   // odd: high nibble used
    push_pixel(16'h001F, 8'hF0);
    push_pixel(16'h8410, 8'hF0);
    push_pixel(16'h7BEF, 8'hA5);
    push_pixel(16'h0821, 8'h5A);
    drain();
    write_reg(CFG_ALPHA_MODE, 7'd0);
    push_pixel(16'hFFFF, 8'h00);
    push_pixel(16'h0000, 8'hFF);
    push_pixel(16'hAAAA, 8'h55);
    push_pixel(16'h5555, 8'hAA);
    // finish the tile so the walker is back at the image origin
    push_random(64 - pixels_sent % 64);
    drain();

    // Tile counts above and at the limit, walked a few tiles in
    src_idle = 1'b0;
    snk_idle = 1'b0;
    write_reg(CFG_TILES_ACROSS, 7'd127);   // above the limit
    write_reg(CFG_TILES_DOWN, 7'd1);
    push_random(64 * 2);
    drain();
    // column 2 is past a single-tile width: it wraps to row 1
    write_reg(CFG_TILES_ACROSS, 7'd0);
    write_reg(CFG_TILES_DOWN, 7'd64);
    write_reg(CFG_ALPHA_MODE, 7'd1);
    push_random(64);
    drain();

    // Counts lowered mid-image: column 1, row 1 become the last ones
    src_idle = 1'b1;
    snk_idle = 1'b1;
    write_reg(CFG_TILES_ACROSS, 7'd3);
    write_reg(CFG_TILES_DOWN, 7'd3);
    push_random(64 * 4 + 10);
    drain();
    write_reg(CFG_TILES_ACROSS, 7'd1);
    write_reg(CFG_TILES_DOWN, 7'd0);
    push_random(60);
    random_sent = pixels_sent;

    // Random phases, mostly small images, reconfigured between most phases
    while (random_sent < 900) begin
      int unsigned n;
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 2) != 0) begin
        drain();
        write_reg(CFG_TILES_ACROSS, pick_tiles());
        write_reg(CFG_TILES_DOWN, pick_tiles());
        write_reg(CFG_ALPHA_MODE, CfgW'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 1) == 0) begin
        drain();
      end
      n = $urandom_range(8, 150);
      push_random(n);
      random_sent += n;
    end

    in_ch.valid <= 1'b0;
    while (pending_pixels != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
